### hdl/rld_pkg.sv
package rld_pkg;

  // Result status codes
  localparam logic [2:0] ST_ENTRY   = 3'd0;
  localparam logic [2:0] ST_END     = 3'd1;
  localparam logic [2:0] ST_BAD_HDR = 3'd2;
  localparam logic [2:0] ST_TRUNC   = 3'd3;
  localparam logic [2:0] ST_NEG     = 3'd4;
  localparam logic [2:0] ST_SPAN    = 3'd5;

  // Largest byte count a header nibble may give
  localparam logic [3:0] MAX_FIELD_BYTES = 4'd8;

  // Parser phase
  typedef enum logic [1:0] {
    PH_HEADER,
    PH_COUNT,
    PH_DELTA,
    PH_STOPPED
  } phase_t;

  // Kind of a queued event
  typedef enum logic [1:0] {
    QK_RECORD,
    QK_STATUS,
    QK_MARKER
  } qkind_t;

  typedef struct packed {
    logic [7:0] run_byte;
    logic       end_of_area;
  } rld_in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [62:0] phys_cluster;
    logic        sparse;
    logic [63:0] run_clusters;
    logic [63:0] first_vcn;
    logic [63:0] end_vcn;
  } rld_out_t;

  // One event handed from the parser to the run tracker
  typedef struct packed {
    qkind_t      kind;
    logic [2:0]  code;
    logic        eoa;
    logic [63:0] run_len;
    logic [63:0] run_len_m1;
    logic [63:0] delta;
  } rld_qent_t;

  // Queue write side
  typedef struct packed {
    logic      valid;
    rld_qent_t ent;
  } rld_push_t;

  // Queue read side
  typedef struct packed {
    logic      valid;
    rld_qent_t ent;
  } rld_head_t;

endpackage

### hdl/rld_front.sv
module rld_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             accept,
  input  rld_pkg::rld_in_t in_data,
  output rld_pkg::rld_push_t push
);
  import rld_pkg::*;

  phase_t      phase_r, phase_nxt;
  logic [3:0]  len_nib_r, len_nib_nxt;
  logic [3:0]  ofs_nib_r, ofs_nib_nxt;
  logic [3:0]  taken_r, taken_nxt;
  logic [63:0] len_acc_r, len_acc_nxt;
  logic [63:0] dly_acc_r, dly_acc_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_HEADER;
      len_nib_r <= '0;
      ofs_nib_r <= '0;
      taken_r   <= '0;
      len_acc_r <= '0;
      dly_acc_r <= '0;
    end else begin
      phase_r   <= phase_nxt;
      len_nib_r <= len_nib_nxt;
      ofs_nib_r <= ofs_nib_nxt;
      taken_r   <= taken_nxt;
      len_acc_r <= len_acc_nxt;
      dly_acc_r <= dly_acc_nxt;
    end
  end

  // Parse one byte, classify it and build the queue event
  always_comb begin
    logic [7:0]  b;
    logic [3:0]  taken_inc;
    logic [63:0] byte_sh;
    logic        complete;
    b          = in_data.run_byte;
    taken_inc  = taken_r + 4'd1;
    byte_sh    = {56'd0, b} << {taken_r[2:0], 3'b000};
    complete   = 1'b0;
    phase_nxt   = phase_r;
    len_nib_nxt = len_nib_r;
    ofs_nib_nxt = ofs_nib_r;
    taken_nxt   = taken_r;
    len_acc_nxt = len_acc_r;
    dly_acc_nxt = dly_acc_r;
    push        = '0;
    push.ent.kind = QK_MARKER;
    if (accept) begin
      case (phase_r)
        PH_HEADER: begin
          if (b == 8'd0) begin
            push.valid    = 1'b1;
            push.ent.kind = QK_STATUS;
            push.ent.code = ST_END;
            phase_nxt     = PH_STOPPED;
          end else if (b[3:0] > MAX_FIELD_BYTES || b[7:4] > MAX_FIELD_BYTES) begin
            push.valid    = 1'b1;
            push.ent.kind = QK_STATUS;
            push.ent.code = ST_BAD_HDR;
            phase_nxt     = PH_STOPPED;
          end else begin
            len_nib_nxt = b[3:0];
            ofs_nib_nxt = b[7:4];
            len_acc_nxt = '0;
            dly_acc_nxt = '0;
            taken_nxt   = '0;
            if (b[3:0] != 4'd0) begin
              phase_nxt = PH_COUNT;
            end else if (b[7:4] != 4'd0) begin
              phase_nxt = PH_DELTA;
            end else begin
              complete = 1'b1;
            end
          end
        end
        PH_COUNT: begin
          len_acc_nxt = len_acc_r | byte_sh;
          taken_nxt   = taken_inc;
          if (taken_inc >= len_nib_r) begin
            if (ofs_nib_r != 4'd0) begin
              phase_nxt = PH_DELTA;
              taken_nxt = '0;
            end else begin
              complete = 1'b1;
            end
          end
        end
        PH_DELTA: begin
          dly_acc_nxt = dly_acc_r | byte_sh;
          taken_nxt   = taken_inc;
          if (taken_inc >= ofs_nib_r) begin
            // sign-extend from the top delta byte
            if (b[7] && ofs_nib_r < MAX_FIELD_BYTES) begin
              dly_acc_nxt = dly_acc_nxt | (~64'd0 << {ofs_nib_r[2:0], 3'b000});
            end
            complete = 1'b1;
          end
        end
        default: begin
        end
      endcase

      if (complete) begin
        push.valid          = 1'b1;
        push.ent.kind       = QK_RECORD;
        push.ent.code       = ST_ENTRY;
        push.ent.run_len    = len_acc_nxt;
        push.ent.run_len_m1 = len_acc_nxt - 64'd1;
        push.ent.delta      = dly_acc_nxt;
        phase_nxt           = PH_HEADER;
      end

      // end of area: flag truncation, always pass a reset mark downstream
      if (in_data.end_of_area) begin
        if (!push.valid) begin
          push.valid = 1'b1;
          if (phase_nxt == PH_COUNT || phase_nxt == PH_DELTA) begin
            push.ent.kind = QK_STATUS;
            push.ent.code = ST_TRUNC;
          end else begin
            push.ent.kind = QK_MARKER;
          end
        end
        push.ent.eoa = 1'b1;
        phase_nxt    = PH_HEADER;
        len_nib_nxt  = '0;
        ofs_nib_nxt  = '0;
        taken_nxt    = '0;
        len_acc_nxt  = '0;
        dly_acc_nxt  = '0;
      end
    end
  end

endmodule

### hdl/rld_queue.sv
module rld_queue #(
  parameter int DEPTH = 2
) (
  input  logic               clk,
  input  logic               rst_n,
  input  rld_pkg::rld_push_t push,
  input  logic               pop,
  output rld_pkg::rld_head_t head,
  output logic               full
);
  import rld_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  rld_qent_t       mem_r [DEPTH];
  logic [AW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic            do_push, do_pop;

  assign do_pop  = pop && (count_r != '0);
  assign do_push = push.valid;
  assign full    = (count_r == CW'(DEPTH));

  assign head.valid = (count_r != '0);
  assign head.ent   = mem_r[rd_ptr_r];

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
    end
    case ({do_push, do_pop})
      2'b10:   count_nxt = count_r + CW'(1);
      2'b01:   count_nxt = count_r - CW'(1);
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push.ent;
    end
  end

endmodule

### hdl/rld_back.sv
module rld_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [63:0]        vcn_span,
  input  rld_pkg::rld_head_t head,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_stall,
  output rld_pkg::rld_out_t  out_data
);
  import rld_pkg::*;

  logic        stopped_r, stopped_nxt;
  logic [63:0] lcn_r, lcn_nxt;
  logic [63:0] vcn_r, vcn_nxt;
  logic        out_valid_r, out_valid_nxt;
  rld_out_t    out_data_r, res;
  logic        emit;
  logic        take;

  assign take      = !out_valid_r || !out_stall;
  assign pop       = head.valid && take;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // carry out one event against the running clusters
  always_comb begin
    logic [63:0] lcn_sum;
    logic [63:0] vcn_sum;
    logic [63:0] last;
    lcn_sum     = lcn_r + head.ent.delta;
    vcn_sum     = vcn_r + head.ent.run_len;
    last        = vcn_r + head.ent.run_len_m1;
    stopped_nxt = stopped_r;
    lcn_nxt     = lcn_r;
    vcn_nxt     = vcn_r;
    emit        = 1'b0;
    res         = '0;
    if (pop) begin
      if (!stopped_r) begin
        case (head.ent.kind)
          QK_RECORD: begin
            emit = 1'b1;
            if (lcn_sum[63]) begin
              res.status  = ST_NEG;
              stopped_nxt = 1'b1;
            end else begin
              lcn_nxt = lcn_sum;
              vcn_nxt = vcn_sum;
              if (last > vcn_span) begin
                res.status  = ST_SPAN;
                stopped_nxt = 1'b1;
              end else begin
                res.status       = ST_ENTRY;
                res.sparse       = (head.ent.delta == 64'd0);
                res.phys_cluster = res.sparse ? 63'd0 : lcn_sum[62:0];
                res.run_clusters = head.ent.run_len;
                res.first_vcn    = vcn_r;
                res.end_vcn      = last;
              end
            end
          end
          QK_STATUS: begin
            emit        = 1'b1;
            res.status  = head.ent.code;
            stopped_nxt = 1'b1;
          end
          default: begin
          end
        endcase
      end
      // end of area clears the running state
      if (head.ent.eoa) begin
        stopped_nxt = 1'b0;
        lcn_nxt     = '0;
        vcn_nxt     = '0;
      end
    end
    out_valid_nxt = take ? (pop && emit) : out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stopped_r   <= 1'b0;
      lcn_r       <= '0;
      vcn_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      stopped_r   <= stopped_nxt;
      lcn_r       <= lcn_nxt;
      vcn_r       <= vcn_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (pop && emit) begin
      out_data_r <= res;
    end
  end

endmodule

### hdl/run_list_decoder.sv
// Extent run list decoder. Takes one run list byte per cycle on the in_
// channel and gives one result item per completed record, terminator, bad
// header, truncation, negative cluster or span overrun on the out_ channel,
// none after a non-entry status until end_of_area. A byte parser classifies
// bytes and queues events into a QUEUE_DEPTH-entry queue; a run tracker does
// the 64-bit cluster add and span compare, one event per cycle, into an
// output register. Sustained rate is one byte per cycle; in_stall rises only
// while the queue is full, which happens when out_stall holds results back.
// vcn_span must be written through cfg_ while idle (not enforced). cfg_ready
// is always high. end_of_area resets the stream state but keeps vcn_span.
module run_list_decoder #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  rld_pkg::rld_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output rld_pkg::rld_out_t out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [63:0]       cfg_data
);
  import rld_pkg::*;

  logic [63:0] span_r;
  rld_push_t   push;
  rld_head_t   head;
  logic        pop;
  logic        full;
  logic        accept;

  assign cfg_ready = 1'b1;
  assign in_stall  = full;
  assign accept    = in_valid && !full;

  // span register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      span_r <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        span_r <= cfg_data;
      end
    end
  end

  rld_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .in_data (in_data),
    .push    (push)
  );

  rld_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .pop   (pop),
    .head  (head),
    .full  (full)
  );

  rld_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .vcn_span  (span_r),
    .head      (head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

### verif/run_list_decoder_test.sv
`timescale 1ns / 100ps

module run_list_decoder_test;
  import rld_pkg::*;

  localparam int CYCLE_LIMIT = 300000;
  localparam int DRAIN_CYCLES = 8;
  localparam int HOLD_CYCLES = 300;
  localparam int SEG_ITEMS = 200;
  localparam logic [63:0] SPAN_MAX = 64'hFFFF_FFFF_FFFF_FFFF;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  rld_in_t     in_data;
  logic        out_valid;
  logic        out_stall;
  rld_out_t    out_data;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [63:0] cfg_data;

  run_list_decoder i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  // Directed stimulus table
  typedef enum logic {ROW_BYTE, ROW_SPAN} row_kind_t;

  typedef struct {
    row_kind_t   kind;
    logic [7:0]  run_byte;
    logic        eoa;
    logic [63:0] span;
    bit          typed;
    logic [2:0]  typed_st;
  } stim_row_t;

  localparam int N_DIR = 28;

  stim_row_t dir_table [N_DIR] = '{
    // span 0 after reset: terminator, zero-count run at cluster 0 wraps past span
    '{ROW_BYTE, 8'h00, 1'b1, 64'd0, 1'b1, ST_END},
    '{ROW_BYTE, 8'h10, 1'b0, 64'd0, 1'b0, ST_ENTRY},
    '{ROW_BYTE, 8'h05, 1'b0, 64'd0, 1'b1, ST_SPAN},
    '{ROW_BYTE, 8'hAA, 1'b1, 64'd0, 1'b0, ST_ENTRY},
    '{ROW_SPAN, 8'h00, 1'b0, SPAN_MAX, 1'b0, ST_ENTRY},
    // oversized count nibble, oversized delta nibble
    '{ROW_BYTE, 8'h09, 1'b1, 64'd0, 1'b1, ST_BAD_HDR},
    '{ROW_BYTE, 8'h90, 1'b1, 64'd0, 1'b1, ST_BAD_HDR},
    // negative delta from cluster 0, then an ignored byte that ends the area
    '{ROW_BYTE, 8'h10, 1'b0, 64'd0, 1'b0, ST_ENTRY},
    '{ROW_BYTE, 8'h80, 1'b0, 64'd0, 1'b1, ST_NEG},
    '{ROW_BYTE, 8'h00, 1'b1, 64'd0, 1'b0, ST_ENTRY},
    // two ordinary runs, the second with a negative delta and no clusters
    '{ROW_BYTE, 8'h21, 1'b0, 64'd0, 1'b0, ST_ENTRY},
    '{ROW_BYTE, 8'h10, 1'b0, 64'd0, 1'b0, ST_ENTRY},
    '{ROW_BYTE, 8'h00, 1'b0, 64'd0, 1'b0, ST_ENTRY},
    '{ROW_BYTE, 8'h10, 1'b0, 64'd0, 1'b0, ST_ENTRY},
    '{ROW_BYTE, 8'h10, 1'b0, 64'd0, 1'b0, ST_ENTRY},
    '{ROW_BYTE, 8'hF0, 1'b0, 64'd0, 1'b0, ST_ENTRY},
    // area ends inside the delta field
    '{ROW_BYTE, 8'h31, 1'b0, 64'd0, 1'b0, ST_ENTRY},
    '{ROW_BYTE, 8'h02, 1'b0, 64'd0, 1'b0, ST_ENTRY},
    '{ROW_BYTE, 8'h00, 1'b1, 64'd0, 1'b1, ST_TRUNC},
    // largest sparse run, area ends on its last byte
    '{ROW_BYTE, 8'h08, 1'b0, 64'd0, 1'b0, ST_ENTRY},
    '{ROW_BYTE, 8'hFF, 1'b0, 64'd0, 1'b0, ST_ENTRY},
    '{ROW_BYTE, 8'hFF, 1'b0, 64'd0, 1'b0, ST_ENTRY},
    '{ROW_BYTE, 8'hFF, 1'b0, 64'd0, 1'b0, ST_ENTRY},
    '{ROW_BYTE, 8'hFF, 1'b0, 64'd0, 1'b0, ST_ENTRY},
    '{ROW_BYTE, 8'hFF, 1'b0, 64'd0, 1'b0, ST_ENTRY},
    '{ROW_BYTE, 8'hFF, 1'b0, 64'd0, 1'b0, ST_ENTRY},
    '{ROW_BYTE, 8'hFF, 1'b0, 64'd0, 1'b0, ST_ENTRY},
    '{ROW_BYTE, 8'hFF, 1'b1, 64'd0, 1'b0, ST_ENTRY}
  };

  // Decoder state mirror
  phase_t      dec_phase;
  logic [3:0]  cnt_len;
  logic [3:0]  dlt_len;
  logic [3:0]  taken;
  logic [63:0] len_acc;
  logic [63:0] dlt_acc;
  logic [63:0] run_lcn;
  logic [63:0] run_vcn;
  logic [63:0] span_reg;

  rld_out_t   pending_runs[$];
  logic [7:0] area_bytes[$];

  int err_cnt = 0;
  int results_seen = 0;
  int sent_items = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  int cycle_cnt = 0;

  function automatic void clear_stream();
    dec_phase = PH_HEADER;
    cnt_len   = '0;
    dlt_len   = '0;
    taken     = '0;
    len_acc   = '0;
    dlt_acc   = '0;
    run_lcn   = '0;
    run_vcn   = '0;
  endfunction

  // Advance the mirror by one byte
  function automatic void decode_byte(input rld_in_t item, output bit has_res,
                                      output rld_out_t res);
    logic [7:0]  b;
    bit          done;
    logic [63:0] lcn_sum;
    logic [63:0] first_v;
    logic [63:0] last_v;
    b       = item.run_byte;
    has_res = 1'b0;
    res     = '0;
    done    = 1'b0;
    case (dec_phase)
      PH_HEADER: begin
        if (b == 8'h00) begin
          has_res    = 1'b1;
          res.status = ST_END;
          dec_phase  = PH_STOPPED;
        end else if (b[3:0] > MAX_FIELD_BYTES || b[7:4] > MAX_FIELD_BYTES) begin
          has_res    = 1'b1;
          res.status = ST_BAD_HDR;
          dec_phase  = PH_STOPPED;
        end else begin
          cnt_len = b[3:0];
          dlt_len = b[7:4];
          len_acc = '0;
          dlt_acc = '0;
          taken   = '0;
          if (cnt_len != 0) dec_phase = PH_COUNT;
          else if (dlt_len != 0) dec_phase = PH_DELTA;
          else done = 1'b1;
        end
      end
      PH_COUNT: begin
        len_acc = len_acc | ({56'd0, b} << (taken * 8));
        taken   = taken + 4'd1;
        if (taken >= cnt_len) begin
          if (dlt_len != 0) begin
            taken     = '0;
            dec_phase = PH_DELTA;
          end else begin
            done = 1'b1;
          end
        end
      end
      PH_DELTA: begin
        dlt_acc = dlt_acc | ({56'd0, b} << (taken * 8));
        taken   = taken + 4'd1;
        if (taken >= dlt_len) begin
          // sign-extend from the top delta byte
          if (b[7] && dlt_len < MAX_FIELD_BYTES) dlt_acc = dlt_acc | (~64'd0 << (dlt_len * 8));
          done = 1'b1;
        end
      end
      default: ;
    endcase

    // Record complete: cluster add, sign check, span check
    if (done) begin
      lcn_sum   = run_lcn + dlt_acc;
      has_res   = 1'b1;
      dec_phase = PH_STOPPED;
      if (lcn_sum[63]) begin
        res.status = ST_NEG;
      end else begin
        run_lcn = lcn_sum;
        first_v = run_vcn;
        run_vcn = run_vcn + len_acc;
        last_v  = run_vcn - 64'd1;
        if (last_v > span_reg) begin
          res.status = ST_SPAN;
        end else begin
          res.status       = ST_ENTRY;
          res.sparse       = (dlt_acc == 64'd0);
          res.phys_cluster = res.sparse ? 63'd0 : lcn_sum[62:0];
          res.run_clusters = len_acc;
          res.first_vcn    = first_v;
          res.end_vcn      = last_v;
          dec_phase        = PH_HEADER;
        end
      end
    end

    // End of area: truncation if a field is still open, then clear
    if (item.end_of_area) begin
      if (!has_res && (dec_phase == PH_COUNT || dec_phase == PH_DELTA)) begin
        has_res    = 1'b1;
        res        = '0;
        res.status = ST_TRUNC;
      end
      clear_stream();
    end
  endfunction

  // Append one byte to the area being built
  function automatic void add_byte(input logic [7:0] v);
    area_bytes.insert(area_bytes.size(), v);
  endfunction

  // One random area of run records with random content
  function automatic void build_area();
    int         n_rec;
    int         pick;
    int         ln;
    int         on;
    bit         zero_delta;
    logic [7:0] db;
    area_bytes.delete();
    n_rec = $urandom_range(1, 5);
    for (int r = 0; r < n_rec; r++) begin
      pick = $urandom_range(0, 99);
      if (pick < 5) begin
        // noise header, may be bad or a terminator
        add_byte(8'($urandom));
      end else begin
        ln = (pick < 50) ? $urandom_range(1, 2) : $urandom_range(0, 8);
        on = $urandom_range(0, 1) ? $urandom_range(1, 3) : $urandom_range(0, 8);
        if (ln == 0 && on == 0) ln = 1;
        zero_delta = ($urandom_range(0, 99) < 15);
        add_byte({4'(on), 4'(ln)});
        for (int i = 0; i < ln; i++)
          add_byte((i == 0 || $urandom_range(0, 7) == 0) ? 8'($urandom) : 8'h00);
        for (int i = 0; i < on; i++) begin
          db = 8'($urandom);
          // mostly positive deltas so lists run on
          if (i == on - 1 && $urandom_range(0, 5) != 0) db[7] = 1'b0;
          add_byte(zero_delta ? 8'h00 : db);
        end
      end
    end
    pick = $urandom_range(0, 99);
    if (pick < 25) begin
      add_byte(8'h00);
      repeat ($urandom_range(0, 3)) add_byte(8'($urandom));
    end else if (pick < 35) begin
      // header needs seven more bytes, area ends first
      add_byte(8'h43);
      repeat ($urandom_range(0, 5)) add_byte(8'($urandom));
    end
  endfunction

  // Offer one item, predict on acceptance
  task automatic send_item(input rld_in_t item, input bit typed, input logic [2:0] typed_st);
    bit       has_res;
    rld_out_t res;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    decode_byte(item, has_res, res);
    if (typed) begin
      res        = '0;
      res.status = typed_st;
      has_res    = 1'b1;
    end
    if (has_res) pending_runs.insert(pending_runs.size(), res);
    sent_items++;
    @(negedge clk);
  endtask

  // Span write once the block has gone quiet
  task automatic write_span(input logic [63:0] value);
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending_runs.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    span_reg = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %h actual %h", name, want, got);
      err_cnt++;
    end
  endfunction

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog
  initial begin
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  // Receiver stall, with one long hold-off to back up the block
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(negedge clk);
      if (!hold_done && results_seen >= 40) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
      end
    end
  end

  // Result checker
  always @(posedge clk) begin
    rld_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_runs.size() == 0) begin
        $error("unexpected result item: status %0d", out_data.status);
        err_cnt++;
      end else begin
        want = pending_runs.pop_front();
        check_field("status", 64'(want.status), 64'(out_data.status));
        check_field("phys_cluster", 64'(want.phys_cluster), 64'(out_data.phys_cluster));
        check_field("sparse", 64'(want.sparse), 64'(out_data.sparse));
        check_field("run_clusters", want.run_clusters, out_data.run_clusters);
        check_field("first_vcn", want.first_vcn, out_data.first_vcn);
        check_field("end_vcn", want.end_vcn, out_data.end_vcn);
        results_seen++;
      end
    end
  end

  // Main sequence
  initial begin
    logic [63:0] next_span;
    rld_in_t     item;
    int          seg_goal;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_valid <= 1'b0;
    cfg_data  <= '0;
    rst_n     <= 1'b0;
    span_reg = '0;
    clear_stream();
    send_idle_pct = 28;
    recv_idle_pct = 63;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed table
    for (int i = 0; i < N_DIR; i++) begin
      if (dir_table[i].kind == ROW_SPAN) begin
        write_span(dir_table[i].span);
      end else begin
        item.run_byte    = dir_table[i].run_byte;
        item.end_of_area = dir_table[i].eoa;
        send_item(item, dir_table[i].typed, dir_table[i].typed_st);
      end
    end

    // Random areas, two segments per idling mode, new span each segment
    for (int seg = 0; seg < 6; seg++) begin
      case (seg / 2)
        0: begin
          send_idle_pct = 28;
          recv_idle_pct = 63;
        end
        1: begin
          send_idle_pct = 63;
          recv_idle_pct = 28;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      case (seg)
        0: next_span = SPAN_MAX;
        1: next_span = 64'd0;
        2: next_span = 64'($urandom_range(0, 5000));
        3: next_span = {$urandom, $urandom};
        4: next_span = 64'h7FFF_FFFF_FFFF_FFFF;
        default: next_span = 64'($urandom_range(50, 100000));
      endcase
      write_span(next_span);
      seg_goal = sent_items + SEG_ITEMS;
      while (sent_items < seg_goal) begin
        build_area();
        foreach (area_bytes[k]) begin
          item.run_byte    = area_bytes[k];
          item.end_of_area = (k == area_bytes.size() - 1);
          send_item(item, 1'b0, ST_ENTRY);
        end
      end
    end

    // Drain
    in_valid <= 1'b0;
    while (pending_runs.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (err_cnt == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule
